// File: src/mcpc_pkg.sv
`default_nettype none
package mcpc_pkg;

    localparam int MAX_POINTS = 512;
    localparam int COS_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int COS_W = $clog2(COS_TABLE_DEPTH);

    localparam logic [1:0] STAGE_HORIZ = 2'd0;
    localparam logic [1:0] STAGE_NOSE  = 2'd1;
    localparam logic [1:0] STAGE_READY = 2'd2;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_NEAR   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] REG_MIN_DIST = 2'd0;
    localparam logic [1:0] REG_LEVEL    = 2'd1;
    localparam logic [1:0] REG_TILT     = 2'd2;

    typedef logic signed [15:0] axis_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
        axis_t z;
    } point_t;

    // cell to neighbor: a stored point and whether the slot is live
    typedef struct packed {
        logic   live;
        point_t pt;
    } slot_t;

    // quarter-wave cosine in Q1.15 from t in Q30
    function automatic logic signed [17:0] quarter_cos(input longint t);
        longint u;
        longint h;
        longint c;
        u = (t * t) >>> 30;
        h = 64'sd987048;
        h = 64'sd22401992 - ((u * h) >>> 30);
        h = 64'sd272375561 - ((u * h) >>> 30);
        h = 64'sd1324675879 - ((u * h) >>> 30);
        c = (64'sd1 <<< 30) - ((u * h) >>> 30);
        if (c < 0)
        begin
            c = 0;
        end
        return 18'((c + 64'sd16384) >>> 15);
    endfunction

    function automatic logic signed [17:0] cos_entry(input int k);
        longint q;
        longint r;
        longint t;
        logic signed [17:0] c;
        q = longint'(4 * k) / COS_TABLE_DEPTH;
        r = longint'(4 * k) - q * COS_TABLE_DEPTH;
        t = (r <<< 30) / COS_TABLE_DEPTH;
        if (q[0])
        begin
            t = (64'sd1 <<< 30) - t;
        end
        c = quarter_cos(t);
        if (q == 1 || q == 2)
        begin
            c = -c;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/mcpc_cell.sv
`default_nettype none
// One storage slot. Points shift in from the left on a store; the probe
// moves one cell per cycle and marks a near hit.
module mcpc_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  clear,
    input  wire                  shift,
    input  wire mcpc_pkg::slot_t slot_in,
    output mcpc_pkg::slot_t      slot_out,
    input  wire                  probe_in_valid,
    input  wire mcpc_pkg::point_t probe_in,
    input  wire                  near_in,
    input  wire [33:0]           min_dist_sq,
    output logic                 probe_out_valid,
    output mcpc_pkg::point_t     probe_out,
    output logic                 near_out
);
    import mcpc_pkg::*;

    logic   live_reg;
    point_t pt_reg;
    logic   pv_reg;
    point_t pp_reg;
    logic   near_reg;
    logic signed [16:0] dx, dy, dz;
    logic [33:0] d;
    logic hit;

    assign dx = 17'(probe_in.x) - 17'(pt_reg.x);
    assign dy = 17'(probe_in.y) - 17'(pt_reg.y);
    assign dz = 17'(probe_in.z) - 17'(pt_reg.z);
    assign d = 34'(34'(dx * dx) + 34'(dy * dy)) + 34'(dz * dz);
    assign hit = live_reg && (d < min_dist_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            pv_reg   <= 1'b0;
            near_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= probe_in_valid && !clear;
            near_reg <= near_in || hit;
            if (clear)
            begin
                live_reg <= 1'b0;
            end
            else if (shift)
            begin
                live_reg <= slot_in.live;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= probe_in;
        if (shift)
        begin
            pt_reg <= slot_in.pt;
        end
    end

    assign slot_out.live   = live_reg;
    assign slot_out.pt     = pt_reg;
    assign probe_out_valid = pv_reg;
    assign probe_out       = pp_reg;
    assign near_out        = near_reg;
endmodule
`default_nettype wire

// File: src/mcpc_chain.sv
`default_nettype none
// Row of MAX_POINTS cells; the probe walks the row, near flag rides along.
module mcpc_chain (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   clear,
    input  wire                   store,
    input  wire mcpc_pkg::point_t store_pt,
    input  wire                   probe_start,
    input  wire mcpc_pkg::point_t probe_pt,
    input  wire [33:0]            min_dist_sq,
    output logic                  probe_done,
    output logic                  near
);
    import mcpc_pkg::*;

    slot_t  slot  [MAX_POINTS+1];
    logic   pv    [MAX_POINTS+1];
    point_t pp    [MAX_POINTS+1];
    logic   nr    [MAX_POINTS+1];

    assign slot[0].live = 1'b1;
    assign slot[0].pt   = store_pt;
    assign pv[0] = probe_start;
    assign pp[0] = probe_pt;
    assign nr[0] = 1'b0;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        mcpc_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .clear           (clear),
            .shift           (store),
            .slot_in         (slot[i]),
            .slot_out        (slot[i+1]),
            .probe_in_valid  (pv[i]),
            .probe_in        (pp[i]),
            .near_in         (nr[i]),
            .min_dist_sq     (min_dist_sq),
            .probe_out_valid (pv[i+1]),
            .probe_out       (pp[i+1]),
            .near_out        (nr[i+1])
        );
    end

    assign probe_done = pv[MAX_POINTS];
    assign near       = nr[MAX_POINTS];
endmodule
`default_nettype wire

// File: src/mag_cal_point_collector_unit.sv
`default_nettype none
// Magnetometer calibration point collector. One result per input
// transaction. Restart items and items that offer no point do not walk
// the row; each point offer walks the probe down a row of MAX_POINTS
// compare cells, one cell per cycle, and an item that passes both
// stages walks the row once in each stage.
// Stored points shift into the row at its head; a full row answers at
// once. Stage 0 checks level via a cosine ROM (both cosines positive,
// squared sum above level_cos_sq); stage 1 checks pitch within tilt_limit
// of minus ninety degrees. Rotation (gyro rate times step) is summed into
// a saturating 48-bit accumulator; more than one turn advances the stage.
// Configuration writes are always taken. Result tdata is held until taken;
// the next input transaction may be accepted and worked on meanwhile.
module mag_cal_point_collector_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: mag_x, mag_y, mag_z, roll_angle, pitch_angle, rate_x, rate_z,
    //        step_time (from bit 0 up)
    input  wire [135:0] s_axis_tdata,
    // tuser: command
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: stage_now, points_held, store_status, zero pad
    output logic [15:0] m_axis_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [1:0]   cfg_index,
    input  wire [33:0]  cfg_data
);
    import mcpc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_TURN  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = -48'sh8000_0000_0000;
    localparam logic [47:0] FULL_TURN = 48'h1_0000_0000;

    logic [33:0] min_dist_reg;
    logic [30:0] level_reg;
    logic [14:0] tilt_reg;

    logic [2:0]  state_reg;
    logic [1:0]  stage_reg;
    logic signed [47:0] acc_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]  status_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    point_t pt_reg;
    logic [15:0] roll_reg, pitch_reg, dt_reg;
    logic signed [19:0] rx_reg, rz_reg;
    logic signed [36:0] prod_reg;

    logic signed [17:0] cos_rom [COS_TABLE_DEPTH];
    logic signed [17:0] cr, cp;
    logic [35:0] sq;
    logic level_ok, tilt_ok, pose_ok;
    logic signed [16:0] pd;
    logic [16:0] pd_abs;
    logic signed [48:0] acc_sum;
    logic [47:0] acc_abs;

    logic chain_clear, chain_store, probe_start, probe_done, near;

    for (genvar k = 0; k < COS_TABLE_DEPTH; k++)
    begin : g_rom
        assign cos_rom[k] = cos_entry(k);
    end

    assign cr = cos_rom[roll_reg[15 -: COS_W]];
    assign cp = cos_rom[pitch_reg[15 -: COS_W]];
    assign sq = 36'(cr * cr) + 36'(cp * cp);
    assign level_ok = (cr > 0) && (cp > 0) && (sq > 36'(level_reg));
    assign pd = 17'($signed(pitch_reg)) + 17'sd16384;
    assign pd_abs = pd[16] ? 17'(-pd) : 17'(pd);
    assign tilt_ok = pd_abs < 17'(tilt_reg);
    assign pose_ok = (stage_reg == STAGE_HORIZ) ? level_ok :
                     (stage_reg == STAGE_NOSE) ? tilt_ok : 1'b0;

    assign acc_sum = 49'(acc_reg) + 49'(prod_reg);
    assign acc_abs = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);

    // a waiting result does not block the input; S_OUT waits for the slot
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    assign chain_clear = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign probe_start = (state_reg == S_ACC) && (32'(count_reg) < MAX_POINTS);
    assign chain_store = (state_reg == S_SCAN) && probe_done && !near;

    mcpc_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (chain_clear),
        .store       (chain_store),
        .store_pt    (pt_reg),
        .probe_start (probe_start),
        .probe_pt    (pt_reg),
        .min_dist_sq (min_dist_reg),
        .probe_done  (probe_done),
        .near        (near)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= '0;
            level_reg     <= 31'd1073741824;
            tilt_reg      <= 15'd2731;
            state_reg     <= S_IDLE;
            stage_reg     <= STAGE_HORIZ;
            acc_reg       <= '0;
            count_reg     <= '0;
            status_reg    <= ST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_DIST: min_dist_reg <= cfg_data;
                    REG_LEVEL:    level_reg <= cfg_data[30:0];
                    REG_TILT:     tilt_reg <= cfg_data[14:0];
                    default:      ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        status_reg <= ST_NONE;
                        if (s_axis_tuser)
                        begin
                            stage_reg <= STAGE_HORIZ;
                            acc_reg   <= '0;
                            count_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    if (pose_ok)
                    begin
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        state_reg <= (stage_reg == STAGE_HORIZ || stage_reg == STAGE_NOSE)
                                     ? S_TURN : S_OUT;
                    end
                end
                S_ACC:
                begin
                    if (acc_sum > 49'(ACC_MAX))
                    begin
                        acc_reg <= ACC_MAX;
                    end
                    else if (acc_sum < 49'(ACC_MIN))
                    begin
                        acc_reg <= ACC_MIN;
                    end
                    else
                    begin
                        acc_reg <= 48'(acc_sum);
                    end
                    if (probe_start)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_TURN;
                    end
                end
                S_SCAN:
                begin
                    if (probe_done)
                    begin
                        if (near)
                        begin
                            status_reg <= ST_NEAR;
                        end
                        else
                        begin
                            status_reg <= ST_STORED;
                            count_reg  <= count_reg + 1'b1;
                        end
                        state_reg <= S_TURN;
                    end
                end
                S_TURN:
                begin
                    if (acc_abs > FULL_TURN)
                    begin
                        acc_reg <= '0;
                        if (stage_reg == STAGE_HORIZ)
                        begin
                            stage_reg <= STAGE_NOSE;
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            stage_reg <= STAGE_READY;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pt_reg.x  <= s_axis_tdata[15:0];
            pt_reg.y  <= s_axis_tdata[31:16];
            pt_reg.z  <= s_axis_tdata[47:32];
            roll_reg  <= s_axis_tdata[63:48];
            pitch_reg <= s_axis_tdata[79:64];
            rx_reg    <= s_axis_tdata[99:80];
            rz_reg    <= s_axis_tdata[119:100];
            dt_reg    <= s_axis_tdata[135:120];
        end
        // rate times step, registered ahead of the accumulate
        prod_reg <= ((stage_reg == STAGE_HORIZ) ? rz_reg : rx_reg)
                    * $signed({1'b0, dt_reg});
        if (state_reg == S_OUT && !out_valid_reg)
        begin
            out_data_reg <= {2'b00, status_reg, 10'(count_reg), stage_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_POINTS)
        else $error("point count beyond store size");
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg != 2'd3)
        else $error("bad stage code");
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_store |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("store without count step");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mcpc_pkg::*;

    // one result transaction as the block should produce it
    typedef struct {
        logic [1:0] stage;
        logic [9:0] held;
        logic [1:0] status;
    } outcome_t;

    localparam longint ONE_Q30   = 64'sd1 <<< 30;
    localparam longint TURN      = 64'sd1 <<< 32;
    localparam longint ACC_TOP   = (64'sd1 <<< 47) - 1;
    localparam longint ACC_BOT   = -(64'sd1 <<< 47);
    localparam int     HOLD_LEN  = 2000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [15:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [33:0]  cfg_data = '0;

    // predictor copy of registers and state
    logic [33:0]  dist_floor;
    logic [30:0]  level_floor;
    logic [14:0]  tilt_band;
    logic [1:0]   phase;
    longint       spin;
    int           n_pts;
    logic signed [15:0] pts [MAX_POINTS][3];

    outcome_t     awaited [$];
    bit           idle_on = 1'b1;
    logic         hold_req = 1'b0;
    int           hold_left = 0;
    int           errors = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           n_stored = 0;
    int           n_near = 0;
    int           n_full = 0;
    int           n_ready = 0;

    mag_cal_point_collector_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // cosine table entry for a binary angle, Q1.15
    function automatic longint cos_of(input logic [15:0] ang);
        longint k, quad, rem, t, u, h, c;
        k = (longint'(ang) * COS_TABLE_DEPTH) >>> 16;
        quad = (4 * k) / COS_TABLE_DEPTH;
        rem = 4 * k - quad * COS_TABLE_DEPTH;
        t = (rem <<< 30) / COS_TABLE_DEPTH;
        if (quad % 2 == 1)
        begin
            t = ONE_Q30 - t;
        end
        // Horner form in u = t^2, each product truncated to Q30
        u = (t * t) >>> 30;
        h = 64'sd987048;
        h = 64'sd22401992 - ((u * h) >>> 30);
        h = 64'sd272375561 - ((u * h) >>> 30);
        h = 64'sd1324675879 - ((u * h) >>> 30);
        c = ONE_Q30 - ((u * h) >>> 30);
        if (c < 0)
        begin
            c = 0;
        end
        c = (c + 16384) >>> 15;
        if (quad == 1 || quad == 2)
        begin
            c = -c;
        end
        return c;
    endfunction

    function automatic logic [1:0] try_store(input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic signed [15:0] pz);
        longint dx, dy, dz;
        if (n_pts >= MAX_POINTS)
        begin
            return ST_FULL;
        end
        for (int i = 0; i < n_pts; i++)
        begin
            dx = longint'(px) - longint'(pts[i][0]);
            dy = longint'(py) - longint'(pts[i][1]);
            dz = longint'(pz) - longint'(pts[i][2]);
            if (dx * dx + dy * dy + dz * dz < longint'(dist_floor))
            begin
                return ST_NEAR;
            end
        end
        pts[n_pts][0] = px;
        pts[n_pts][1] = py;
        pts[n_pts][2] = pz;
        n_pts++;
        return ST_STORED;
    endfunction

    function automatic void spin_add(input longint rate, input longint dt);
        longint s;
        s = spin + rate * dt;
        if (s > ACC_TOP)
        begin
            s = ACC_TOP;
        end
        if (s < ACC_BOT)
        begin
            s = ACC_BOT;
        end
        spin = s;
    endfunction

    function automatic bit spin_done();
        return (spin < 0 ? -spin : spin) > TURN;
    endfunction

    function automatic outcome_t collect_step(input logic cmd, input logic [135:0] d);
        outcome_t o;
        logic signed [15:0] mx, my, mz, pitch;
        logic [15:0] roll;
        logic signed [19:0] rx, rz;
        longint cr, cp, pitch_gap;
        o.status = ST_NONE;
        mx = d[15:0];
        my = d[31:16];
        mz = d[47:32];
        roll = d[63:48];
        pitch = d[79:64];
        rx = d[99:80];
        rz = d[119:100];
        if (cmd)
        begin
            phase = STAGE_HORIZ;
            spin = 0;
            n_pts = 0;
        end
        else
        begin
            if (phase == STAGE_HORIZ)
            begin
                cr = cos_of(roll);
                cp = cos_of(pitch);
                if (cr > 0 && cp > 0 && cr * cr + cp * cp > longint'(level_floor))
                begin
                    spin_add(rz, longint'(d[135:120]));
                    o.status = try_store(mx, my, mz);
                end
                if (spin_done())
                begin
                    spin = 0;
                    phase = STAGE_NOSE;
                end
            end
            // falls through: an item ending the level stage is tested again here
            if (phase == STAGE_NOSE)
            begin
                pitch_gap = longint'(pitch) + 16384;
                if (pitch_gap < 0)
                begin
                    pitch_gap = -pitch_gap;
                end
                if (pitch_gap < longint'(tilt_band))
                begin
                    spin_add(rx, longint'(d[135:120]));
                    o.status = try_store(mx, my, mz);
                end
                if (spin_done())
                begin
                    spin = 0;
                    phase = STAGE_READY;
                end
            end
        end
        o.stage = phase;
        o.held = n_pts[9:0];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    task automatic send_item(input logic cmd, input logic [135:0] d);
        while (idle_on && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        awaited.push_back(collect_step(cmd, d));
        n_items++;
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [33:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_MIN_DIST: dist_floor = val;
            REG_LEVEL:    level_floor = val[30:0];
            REG_TILT:     tilt_band = val[14:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [33:0] md, input logic [33:0] lv,
                            input logic [33:0] tl);
        write_reg(REG_MIN_DIST, md);
        write_reg(REG_LEVEL, lv);
        write_reg(REG_TILT, tl);
    endtask

    function automatic logic [135:0] pack_item(input int mx, input int my, input int mz,
                                               input int roll, input int pitch,
                                               input int rx, input int rz, input int dt);
        return {dt[15:0], rz[19:0], rx[19:0], pitch[15:0], roll[15:0],
                mz[15:0], my[15:0], mx[15:0]};
    endfunction

    function automatic logic [135:0] noise_bits();
        return 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
    endfunction

    // ---------------------------------------------------------------
    // Receiving and checking
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_LEN;
        end
        else
        begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %h arrived with nothing expected", m_axis_tdata);
                end
            end
            else
            begin
                want = awaited.pop_front();
                if (m_axis_tdata[1:0] !== want.stage || m_axis_tdata[11:2] !== want.held
                    || m_axis_tdata[13:12] !== want.status)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("result %0d: stage %0d/%0d held %0d/%0d status %0d/%0d",
                                 n_results, want.stage, m_axis_tdata[1:0], want.held,
                                 m_axis_tdata[11:2], want.status, m_axis_tdata[13:12]);
                    end
                end
                case (want.status)
                    ST_STORED: n_stored++;
                    ST_NEAR:   n_near++;
                    ST_FULL:   n_full++;
                    default: ;
                endcase
                if (want.stage == STAGE_READY)
                begin
                    n_ready++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // field extremes, the non-level poses, both stage transitions,
    // a double offer in one transaction and the ready stage
    task automatic test_directed();
        send_item(1'b1, noise_bits());
        send_item(1'b0, pack_item(-32768, -32768, -32768, 0, 0, 0, 0, 0));
        send_item(1'b0, pack_item(-32768, -32768, -32768, 0, 0, 0, 0, 0));
        send_item(1'b0, pack_item(32767, 32767, 32767, 0, 0, 524287, 524287, 65535));
        send_item(1'b0, pack_item(100, -200, 300, 0, -16384, -524288, 0, 65535));
        send_item(1'b0, pack_item(5, 5, 5, 0, -16384, 524287, 524287, 65535));
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
        send_item(1'b0, pack_item(1, 2, 3, -32768, 0, 0, 0, 100));
        send_item(1'b0, pack_item(1, 2, 3, 16384, 0, 0, 0, 100));
        send_item(1'b0, pack_item(1, 2, 3, 0, 32767, 0, 0, 100));
        send_item(1'b0, pack_item(1, 2, 3, 0, -32768, 0, 0, 100));
        send_item(1'b0, pack_item(1, 2, 3, 255, -255, 0, -524288, 65535));
        send_item(1'b0, pack_item(7, 8, 9, 0, 32767, 0, 0, 100));
        drain();
        // wide tilt band: a level pose also counts as nose down
        set_regs(34'd1, 34'd1073741824, 34'd16384);
        send_item(1'b1, '0);
        send_item(1'b0, pack_item(40, 50, 60, -1, -1, 524287, 524287, 65535));
        send_item(1'b0, pack_item(40, 50, 60, 0, 0, 0, 0, 0));
        send_item(1'b1, '0);
        send_item(1'b0, pack_item(40, 50, 60, 0, -32768, 0, 0, 10));
        drain();
        // only a pose with both cosines at full scale is level, nothing nose down
        set_regs(34'h3_FFFF_FFFF, 34'h7FFF_FFFF, 34'd0);
        send_item(1'b0, pack_item(1, 1, 1, 0, 0, 1000, 1000, 1000));
        send_item(1'b0, pack_item(1, 1, 1, 0, -16384, 1000, 1000, 1000));
        drain();
        set_regs(34'h3_FFFF_FFFF, 34'd0, 34'd2731);
        send_item(1'b1, '0);
        send_item(1'b0, pack_item(-32768, 0, 32767, 100, 100, 0, 0, 0));
        send_item(1'b0, pack_item(32767, 0, -32768, 100, 100, 0, 0, 0));
        drain();
    endtask

    // fill the store to capacity and beyond
    task automatic test_store_fill();
        set_regs(34'd0, 34'd1073741824, 34'd2731);
        send_item(1'b1, '0);
        for (int i = 0; i < MAX_POINTS + 3; i++)
        begin
            send_item(1'b0, pack_item($urandom, $urandom, $urandom,
                                      $urandom_range(0, 2000), 0, 0, 0, 0));
        end
        drain();
    endtask

    // receiver holds off while items keep coming, then the sender waits
    task automatic test_backpressure();
        send_item(1'b1, '0);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            send_item(1'b0, pack_item($urandom, $urandom, $urandom, 0, 0, 0, 3000, 30000));
        end
        drain();
    endtask

    // mostly well-formed collection runs with random content, plus noise
    task automatic test_random_runs(input int count);
        int r, wid, rate, bx, by, bz;
        bx = 0;
        by = 0;
        bz = 0;
        send_item(1'b1, '0);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(1))
            begin
                bx = $urandom;
                by = $urandom;
                bz = $urandom;
            end
            else
            begin
                bx += $urandom_range(0, 1200) - 600;
                by += $urandom_range(0, 1200) - 600;
                bz += $urandom_range(0, 1200) - 600;
            end
            wid = $urandom_range(0, 3500);
            rate = $urandom_range(0, 60000);
            if ($urandom_range(1))
            begin
                rate = -rate;
            end
            if (r < 4 || (phase == STAGE_READY && r < 40))
            begin
                send_item(1'b1, noise_bits());
            end
            else if (r < 80 && phase == STAGE_HORIZ)
            begin
                send_item(1'b0, pack_item(bx, by, bz, $urandom_range(0, 2 * wid) - wid,
                                          $urandom_range(0, 2 * wid) - wid,
                                          $urandom, rate, $urandom_range(0, 65535)));
            end
            else if (r < 80)
            begin
                send_item(1'b0, pack_item(bx, by, bz, $urandom,
                                          -16384 + $urandom_range(0, 2 * wid) - wid,
                                          rate, $urandom, $urandom_range(0, 65535)));
            end
            else
            begin
                send_item($urandom_range(99) < 3, noise_bits());
            end
        end
        drain();
    endtask

    initial
    begin
        dist_floor = '0;
        level_floor = 31'd1073741824;
        tilt_band = 15'd2731;
        phase = STAGE_HORIZ;
        spin = 0;
        n_pts = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_store_fill();
        test_backpressure();
        set_regs(34'd0, 34'd1073741824, 34'd2731);
        test_random_runs(5);
        set_regs(34'd1 << 20, 34'd1610612736, 34'd16384);
        test_random_runs(5);
        // a stretch with no idling on either side
        idle_on = 1'b0;
        set_regs(34'd1 << 24, 34'd0, 34'd3500);
        test_random_runs(8);
        idle_on = 1'b1;
        set_regs(34'h3_FFFF_FFFF, 34'd1073741824, 34'd1000);
        test_random_runs(5);
        set_regs(34'd5000, 34'h7FFF_FFFF, 34'd0);
        test_random_runs(4);
        set_regs(34'($urandom_range(0, 1 << 22)), 34'($urandom),
                 34'($urandom_range(0, 16384)));
        test_random_runs(5);
        repeat (30) @(posedge clk);

        $display("%0d transactions in, %0d results checked, %0d errors", n_items,
                 n_results, errors);
        $display("stored %0d, too near %0d, store full %0d, ready stage seen %0d times",
                 n_stored, n_near, n_full, n_ready);
        if (errors == 0 && awaited.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: mag_cal_point_collector_unit.f
src/mcpc_pkg.sv
src/mcpc_cell.sv
src/mcpc_chain.sv
src/mag_cal_point_collector_unit.sv
tb/testbench.sv
